@@ rtl/lfpf_pkg.sv @@
`timescale 1ns / 1ps

package lfpf_pkg;

    localparam logic [7:0]  HEADER_BYTE     = 8'h59;
    localparam logic [3:0]  FRAME_LAST      = 4'd8;
    localparam logic [15:0] DISTANCE_LIMIT  = 16'd65532;
    localparam int          FRAC_BITS       = 8;
    localparam int          AVG_WINDOW_DEF  = 5;

    localparam logic [9:0]  RATE_RST        = 10'd100;
    localparam logic [15:0] MIN_STR_RST     = 16'd100;
    localparam logic [7:0]  DEADBAND_RST    = 8'd2;

    localparam int          CFG_AW          = 4;
    localparam int          CFG_DW          = 32;

    typedef enum logic [1:0] {
        REG_RATE     = 2'd0,
        REG_MIN_STR  = 2'd1,
        REG_DEADBAND = 2'd2
    } t_reg_idx;

    // One parsed frame handed from the parser to the filter.
    typedef struct packed {
        logic [15:0] dist_raw;
        logic [15:0] strength;
    } t_frame;

    typedef struct packed {
        logic [9:0]  rate_hz;
        logic [15:0] min_strength;
        logic [7:0]  deadband_cm;
    } t_cfg;

    typedef struct packed {
        logic [23:0] altitude_fixed;
        logic [34:0] velocity_fixed;
        logic [15:0] distance_raw;
        logic [15:0] strength_raw;
        logic        reading_valid;
    } t_result;

endpackage

@@ rtl/lidar_frame_parse_and_filter_core.sv @@
`timescale 1ns / 1ps

// Rangefinder serial frame parser with deadband, moving average and velocity.
//
// Input channel: one received serial byte per word, pushed with i_push while
// o_full is low. The parser hunts for the 0x59 0x59 header, gathers the nine
// byte frame and checks the 8-bit sum; a bad frame is dropped silently.
// A good frame enters a two-word queue toward the filter.
// Result channel: one word per good frame, read with i_pop while o_empty is
// low, through a two-word output queue.
// Throughput: one byte per cycle. The filter works on a frame in steps
// (deadband, window sum, quotient, remainder and fraction divide steps,
// velocity multiply, push) and is done before the next nine bytes are in,
// so bytes never stall unless the result side does. A frame reaches o_empty
// through the frame queue, the filter steps and the result queue.
// Stall: when nobody pops, results back up into the filter, then the frame
// queue, and o_full rises only after two good frames wait there.
// Reset (synchronous, i_rst_n low): parser goes back to hunting, queues
// empty, the average window, held distance and previous altitude clear, and
// the registers return to rate 100 Hz, min strength 100, deadband 2 cm.
// Registers on the APB port: 0x0 rate_hz, 0x4 min_strength, 0x8 deadband_cm.
module lidar_frame_parse_and_filter_core
    import lfpf_pkg::*;
#(
    parameter int AVERAGE_WINDOW = AVG_WINDOW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input
    input  logic               i_push,
    output logic               o_full,
    input  logic [7:0]         i_rx_byte,
    // result output
    output logic               o_empty,
    input  logic               i_pop,
    output logic [23:0]        o_altitude_fixed,
    output logic signed [34:0] o_velocity_fixed,
    output logic [15:0]        o_distance_raw,
    output logic [15:0]        o_strength_raw,
    output logic               o_reading_valid,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [CFG_DW-1:0]  pwdata,
    output logic [CFG_DW-1:0]  prdata,
    output logic               pready
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    logic     w_accept;
    t_frame   w_frame;
    logic     w_frame_push;
    t_frame   w_mid_frame;
    logic     w_mid_full;
    logic     w_mid_empty;
    logic     w_mid_pop;
    t_result  w_result;
    logic     w_res_push;
    logic     w_res_full;
    t_result  w_out;

    // Configuration: always ready, write on the access phase.
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_hz      <= RATE_RST;
            r_cfg.min_strength <= MIN_STR_RST;
            r_cfg.deadband_cm  <= DEADBAND_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_RATE:     r_cfg.rate_hz      <= pwdata[9:0];
                REG_MIN_STR:  r_cfg.min_strength <= pwdata[15:0];
                REG_DEADBAND: r_cfg.deadband_cm  <= pwdata[7:0];
                default:      r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RATE:     prdata = {22'd0, r_cfg.rate_hz};
            REG_MIN_STR:  prdata = {16'd0, r_cfg.min_strength};
            REG_DEADBAND: prdata = {24'd0, r_cfg.deadband_cm};
            default:      prdata = '0;
        endcase
    end

    // Front: hold bytes off only while the frame queue is full.
    assign o_full   = w_mid_full;
    assign w_accept = i_push && !w_mid_full;

    lfpf_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_rx_byte),
        .o_frame  (w_frame),
        .o_push   (w_frame_push)
    );

    lfpf_fifo #(
        .WIDTH ($bits(t_frame))
    ) u_frame_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_frame_push),
        .i_wdata (w_frame),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_rdata (w_mid_frame),
        .o_empty (w_mid_empty)
    );

    // Back: deadband, average and velocity, one frame at a time.
    lfpf_filter #(
        .AVERAGE_WINDOW (AVERAGE_WINDOW)
    ) u_filter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_frame       (w_mid_frame),
        .i_frame_empty (w_mid_empty),
        .o_frame_pop   (w_mid_pop),
        .o_result      (w_result),
        .o_res_push    (w_res_push),
        .i_res_full    (w_res_full)
    );

    lfpf_fifo #(
        .WIDTH ($bits(t_result))
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_result),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_rdata (w_out),
        .o_empty (o_empty)
    );

    assign o_altitude_fixed = w_out.altitude_fixed;
    assign o_velocity_fixed = $signed(w_out.velocity_fixed);
    assign o_distance_raw   = w_out.distance_raw;
    assign o_strength_raw   = w_out.strength_raw;
    assign o_reading_valid  = w_out.reading_valid;

endmodule

@@ rtl/lfpf_fifo.sv @@
`timescale 1ns / 1ps

module lfpf_fifo
    import lfpf_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;
    assign o_rdata   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wr <= ~r_wr;
            end
            if (w_do_pop) begin
                r_rd <= ~r_rd;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

@@ rtl/lfpf_parser.sv @@
`timescale 1ns / 1ps

module lfpf_parser
    import lfpf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output t_frame     o_frame,
    output logic       o_push
);

    localparam logic [3:0] POS_HUNT    = 4'd0;
    localparam logic [3:0] POS_HDR2    = 4'd1;
    localparam logic [3:0] POS_DIST_LO = 4'd2;
    localparam logic [3:0] POS_DIST_HI = 4'd3;
    localparam logic [3:0] POS_STR_LO  = 4'd4;
    localparam logic [3:0] POS_STR_HI  = 4'd5;

    logic [3:0] r_pos;
    logic [7:0] r_sum;
    logic [7:0] r_dist_lo;
    logic [7:0] r_dist_hi;
    logic [7:0] r_str_lo;
    logic [7:0] r_str_hi;

    assign o_frame.dist_raw = {r_dist_hi, r_dist_lo};
    assign o_frame.strength = {r_str_hi, r_str_lo};
    assign o_push = i_accept && (r_pos == FRAME_LAST) && (i_byte == r_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
            r_sum <= 8'd0;
        end else if (i_accept) begin
            case (r_pos)
                POS_HUNT: begin
                    if (i_byte == HEADER_BYTE) begin
                        r_sum <= i_byte;
                        r_pos <= POS_HDR2;
                    end
                end
                POS_HDR2: begin
                    if (i_byte == HEADER_BYTE) begin
                        r_sum <= r_sum + i_byte;
                        r_pos <= POS_DIST_LO;
                    end else begin
                        r_pos <= POS_HUNT;
                    end
                end
                default: begin
                    if (r_pos < FRAME_LAST) begin
                        r_sum <= r_sum + i_byte;
                        r_pos <= r_pos + 4'd1;
                    end else begin
                        r_pos <= POS_HUNT;
                    end
                end
            endcase
        end
    end

    // Capture the distance and strength bytes as they pass.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            case (r_pos)
                POS_DIST_LO: r_dist_lo <= i_byte;
                POS_DIST_HI: r_dist_hi <= i_byte;
                POS_STR_LO:  r_str_lo  <= i_byte;
                POS_STR_HI:  r_str_hi  <= i_byte;
                default:     r_str_hi  <= r_str_hi;
            endcase
        end
    end

endmodule

@@ rtl/lfpf_filter.sv @@
`timescale 1ns / 1ps

module lfpf_filter
    import lfpf_pkg::*;
#(
    parameter int AVERAGE_WINDOW = AVG_WINDOW_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_frame  i_frame,
    input  logic    i_frame_empty,
    output logic    o_frame_pop,
    output t_result o_result,
    output logic    o_res_push,
    input  logic    i_res_full
);

    localparam int SUM_W = 16 + $clog2(AVERAGE_WINDOW);
    localparam int REM_W = (AVERAGE_WINDOW > 1) ? $clog2(AVERAGE_WINDOW) : 1;
    localparam int SHIFT = SUM_W + 4;
    localparam int M_W   = SHIFT + 1;
    localparam logic [M_W-1:0] RECIP =
        M_W'(((64'd1 << SHIFT) + 64'(AVERAGE_WINDOW) - 64'd1) / 64'(AVERAGE_WINDOW));
    localparam logic [SUM_W-1:0] WIN_CONST = SUM_W'(AVERAGE_WINDOW);
    localparam int FX_W  = REM_W + FRAC_BITS;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DEAD = 8'b0000_0010,
        ST_SUM  = 8'b0000_0100,
        ST_QUO  = 8'b0000_1000,
        ST_REM  = 8'b0001_0000,
        ST_FRAC = 8'b0010_0000,
        ST_VEL  = 8'b0100_0000,
        ST_PUSH = 8'b1000_0000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [15:0]        r_raw;
    logic [15:0]        r_str;
    logic [15:0]        r_dist;
    logic               r_valid;
    logic [15:0]        r_held;
    logic [15:0]        r_win [AVERAGE_WINDOW];
    logic [SUM_W-1:0]   r_sum;
    logic [15:0]        r_q1;
    logic [REM_W-1:0]   r_rem;
    logic [23:0]        r_alt;
    logic [23:0]        r_prev;
    logic [34:0]        r_vel;

    logic [16:0]            w_diff;
    logic [16:0]            w_mag;
    logic [15:0]            w_dist;
    logic [SUM_W-1:0]       w_sum;
    logic [SUM_W+M_W-1:0]   w_quo_prod;
    logic [SUM_W-1:0]       w_q1w;
    logic [SUM_W-1:0]       w_rem;
    logic [FX_W+M_W-1:0]    w_frac_prod;
    logic [24:0]            w_alt_diff;
    logic [35:0]            w_vel_prod;

    // Deadband against the last distance used.
    always_comb begin
        w_diff = {1'b0, r_raw} - {1'b0, r_held};
        w_mag  = w_diff[16] ? (17'd0 - w_diff) : w_diff;
        w_dist = (w_mag < {9'd0, i_cfg.deadband_cm}) ? r_held : r_raw;
    end

    always_comb begin
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < AVERAGE_WINDOW; k++) begin
            acc = acc + SUM_W'(r_win[k]);
        end
        w_sum = acc;
    end

    // Divide by the window length with reciprocal multiplies: quotient, remainder, then fraction.
    assign w_quo_prod  = (SUM_W+M_W)'(r_sum) * (SUM_W+M_W)'(RECIP);
    assign w_q1w       = SUM_W'(r_q1) * WIN_CONST;
    assign w_rem       = r_sum - w_q1w;
    assign w_frac_prod = (FX_W+M_W)'({r_rem, {FRAC_BITS{1'b0}}}) * (FX_W+M_W)'(RECIP);
    assign w_alt_diff  = {1'b0, r_alt} - {1'b0, r_prev};
    assign w_vel_prod  = $signed(w_alt_diff) * $signed({1'b0, i_cfg.rate_hz});

    assign o_frame_pop = (r_state == ST_IDLE) && !i_frame_empty;
    assign o_res_push  = (r_state == ST_PUSH);

    assign o_result.altitude_fixed = r_alt;
    assign o_result.velocity_fixed = r_vel;
    assign o_result.distance_raw   = r_dist;
    assign o_result.strength_raw   = r_str;
    assign o_result.reading_valid  = r_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (!i_frame_empty) n_state = ST_DEAD;
            ST_DEAD: n_state = ST_SUM;
            ST_SUM:  n_state = ST_QUO;
            ST_QUO:  n_state = ST_REM;
            ST_REM:  n_state = ST_FRAC;
            ST_FRAC: n_state = ST_VEL;
            ST_VEL:  n_state = ST_PUSH;
            ST_PUSH: if (!i_res_full) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= 16'd0;
            r_prev  <= 24'd0;
            for (int k = 0; k < AVERAGE_WINDOW; k++) begin
                r_win[k] <= 16'd0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_DEAD) begin
                r_held   <= w_dist;
                r_win[0] <= w_dist;
                for (int k = 1; k < AVERAGE_WINDOW; k++) begin
                    r_win[k] <= r_win[k-1];
                end
            end
            if (r_state == ST_VEL) begin
                r_prev <= r_alt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_raw <= i_frame.dist_raw;
                r_str <= i_frame.strength;
            end
            ST_DEAD: begin
                r_dist  <= w_dist;
                r_valid <= (r_str >= i_cfg.min_strength) && (w_dist <= DISTANCE_LIMIT);
            end
            ST_SUM:  r_sum <= w_sum;
            ST_QUO:  r_q1  <= 16'(w_quo_prod >> SHIFT);
            ST_REM:  r_rem <= REM_W'(w_rem);
            ST_FRAC: r_alt <= {r_q1, 8'(w_frac_prod >> SHIFT)};
            ST_VEL:  r_vel <= 35'(w_vel_prod);
            default: r_vel <= r_vel;
        endcase
    end

endmodule

@@ sim/lfpf_reading_checker.sv @@
`timescale 1ns / 1ps

module lfpf_reading_checker
    import lfpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_empty,
    input  logic              i_pop,
    input  logic [23:0]       i_altitude_fixed,
    input  logic [34:0]       i_velocity_fixed,
    input  logic [15:0]       i_distance_raw,
    input  logic [15:0]       i_strength_raw,
    input  logic              i_reading_valid,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    output int                o_pending,
    output int                o_fail_count
);

    localparam int         WIN_LEN        = AVG_WINDOW_DEF;
    localparam logic [3:0] FIELD_LAST_POS = 4'd5;

    t_cfg        cfg;
    logic [3:0]  byte_pos;
    logic [7:0]  run_sum;
    logic [7:0]  field_buf [4];
    logic [15:0] held_dist;
    logic [15:0] dist_hist [WIN_LEN];
    logic [23:0] last_alt;
    t_result     readings_due [$];
    int          fails = 0;

    // Deadband, window average and velocity for one frame that passed its checksum.
    task automatic filter_frame();
        t_result     r;
        logic [15:0] raw;
        logic [15:0] strength;
        logic [15:0] used_dist;
        logic [31:0] win_sum;
        longint      climb;
        int          gap;
        int          k;
        raw      = {field_buf[1], field_buf[0]};
        strength = {field_buf[3], field_buf[2]};
        gap      = int'(raw) - int'(held_dist);
        if (gap < 0) begin
            gap = -gap;
        end
        used_dist = (gap < int'(cfg.deadband_cm)) ? held_dist : raw;
        held_dist = used_dist;
        for (k = WIN_LEN - 1; k > 0; k--) begin
            dist_hist[k] = dist_hist[k - 1];
        end
        dist_hist[0] = used_dist;
        win_sum = '0;
        for (k = 0; k < WIN_LEN; k++) begin
            win_sum = win_sum + dist_hist[k];
        end
        r.altitude_fixed = 24'((win_sum << FRAC_BITS) / WIN_LEN);
        climb = (longint'(r.altitude_fixed) - longint'(last_alt)) * longint'(cfg.rate_hz);
        last_alt         = r.altitude_fixed;
        r.velocity_fixed = climb[34:0];
        r.distance_raw   = used_dist;
        r.strength_raw   = strength;
        r.reading_valid  = (strength >= cfg.min_strength) && (used_dist <= DISTANCE_LIMIT);
        readings_due.push_back(r);
    endtask

    // Advance the frame parser by one byte.
    task automatic absorb_byte(logic [7:0] b);
        if (byte_pos == 4'd0) begin
            if (b == HEADER_BYTE) begin
                run_sum  = b;
                byte_pos = 4'd1;
            end
        end else if (byte_pos == 4'd1) begin
            if (b == HEADER_BYTE) begin
                run_sum  = run_sum + b;
                byte_pos = 4'd2;
            end else begin
                byte_pos = 4'd0;
            end
        end else if (byte_pos < FRAME_LAST) begin
            if (byte_pos <= FIELD_LAST_POS) begin
                field_buf[2'(byte_pos - 4'd2)] = b;
            end
            run_sum  = run_sum + b;
            byte_pos = byte_pos + 4'd1;
        end else begin
            byte_pos = 4'd0;
            if (b == run_sum) begin
                filter_frame();
            end
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg       = '{rate_hz: RATE_RST, min_strength: MIN_STR_RST,
                          deadband_cm: DEADBAND_RST};
            byte_pos  = 4'd0;
            run_sum   = 8'd0;
            held_dist = 16'd0;
            last_alt  = 24'd0;
            for (int k = 0; k < WIN_LEN; k++) begin
                dist_hist[k] = 16'd0;
            end
            readings_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[CFG_AW-1:2]))
                    REG_RATE:     cfg.rate_hz      = i_pwdata[9:0];
                    REG_MIN_STR:  cfg.min_strength = i_pwdata[15:0];
                    REG_DEADBAND: cfg.deadband_cm  = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                absorb_byte(i_rx_byte);
            end
            if (i_pop && !i_empty) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: reading with none expected, got altitude 0x%0h distance 0x%0h",
                             $time, i_altitude_fixed, i_distance_raw);
                    fails++;
                end else begin
                    want = readings_due.pop_front();
                    check_field("altitude_fixed", {40'd0, want.altitude_fixed},
                                {40'd0, i_altitude_fixed});
                    check_field("velocity_fixed", {29'd0, want.velocity_fixed},
                                {29'd0, i_velocity_fixed});
                    check_field("distance_raw", {48'd0, want.distance_raw},
                                {48'd0, i_distance_raw});
                    check_field("strength_raw", {48'd0, want.strength_raw},
                                {48'd0, i_strength_raw});
                    check_field("reading_valid", {63'd0, want.reading_valid},
                                {63'd0, i_reading_valid});
                end
            end
        end
        o_pending    <= readings_due.size();
        o_fail_count <= fails;
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import lfpf_pkg::*;

    localparam int                LIMIT_CYCLES = 400_000;
    // Margin after the last reading for the filter and the queues to empty.
    localparam int                DRAIN_CYCLES = 20;
    localparam int                PHASE_BYTES  = 180;
    localparam int                N_PHASES     = 6;
    // Address past the last register; writes there must be ignored.
    localparam logic [CFG_AW-1:0] SPARE_ADDR   = 4'hC;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_push;
    logic               o_full;
    logic [7:0]         i_rx_byte;
    logic               o_empty;
    logic               i_pop = 1'b0;
    logic [23:0]        o_altitude_fixed;
    logic signed [34:0] o_velocity_fixed;
    logic [15:0]        o_distance_raw;
    logic [15:0]        o_strength_raw;
    logic               o_reading_valid;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [CFG_AW-1:0]  paddr;
    logic [CFG_DW-1:0]  pwdata;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;

    int          readings_pending;
    int          fail_count;
    int          cycles     = 0;
    int          stall_left = 0;
    logic        pop_stalls = 1'b1;
    bit          gaps_on;
    int          bytes_sent;
    logic [15:0] last_dist;
    logic [15:0] cur_min;
    logic [7:0]  cur_db;

    lidar_frame_parse_and_filter_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_rx_byte        (i_rx_byte),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_altitude_fixed (o_altitude_fixed),
        .o_velocity_fixed (o_velocity_fixed),
        .o_distance_raw   (o_distance_raw),
        .o_strength_raw   (o_strength_raw),
        .o_reading_valid  (o_reading_valid),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Watch both channels and the register port, predict every reading and compare.
    lfpf_reading_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .i_full           (o_full),
        .i_rx_byte        (i_rx_byte),
        .i_empty          (o_empty),
        .i_pop            (i_pop),
        .i_altitude_fixed (o_altitude_fixed),
        .i_velocity_fixed (o_velocity_fixed),
        .i_distance_raw   (o_distance_raw),
        .i_strength_raw   (o_strength_raw),
        .i_reading_valid  (o_reading_valid),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_pending        (readings_pending),
        .o_fail_count     (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: no correct run gets anywhere near this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("lidar_frame_parse_and_filter_core: mismatch");
            $finish;
        end
    end

    // Result side: pop freely, or stall in bursts, mostly short and now and then long.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_pop      <= 1'b0;
        end else if (pop_stalls && $urandom_range(0, 99) < 20) begin
            stall_left <= ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                       : $urandom_range(9, 39);
            i_pop      <= 1'b0;
        end else begin
            i_pop <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        if (!gaps_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_AW-1:0] reg_addr(t_reg_idx idx);
        return {idx, 2'b00};
    endfunction

    // Distances: often close to the last one so the deadband gets exercised,
    // some at the validity limit and at zero, the rest anywhere.
    function automatic logic [15:0] pick_dist();
        int r;
        int span;
        int d;
        r    = $urandom_range(0, 99);
        span = int'(cur_db) + 2;
        if (r < 45) begin
            d = int'(last_dist) + int'($urandom_range(0, 2 * span)) - span;
            if (d < 0) begin
                d = 0;
            end
            if (d > 65535) begin
                d = 65535;
            end
            return 16'(d);
        end
        if (r < 55) begin
            return 16'(65535 - $urandom_range(0, 4));
        end
        if (r < 60) begin
            return 16'($urandom_range(0, 3));
        end
        return 16'($urandom);
    endfunction

    // Strengths: often at or next to the minimum, otherwise anywhere.
    function automatic logic [15:0] pick_strength();
        int d;
        if ($urandom_range(0, 99) < 35) begin
            d = int'(cur_min) + int'($urandom_range(0, 2)) - 1;
            if (d < 0) begin
                d = 0;
            end
            if (d > 65535) begin
                d = 65535;
            end
            return 16'(d);
        end
        return 16'($urandom);
    endfunction

    // Present one word and hold it until the block takes it, then maybe idle.
    // Leave push high when the next word follows at once.
    task automatic send_byte(logic [7:0] b);
        int gap;
        i_push    <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_full);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic idle_input();
        i_push <= 1'b0;
    endtask

    // Build a nine-byte frame; a bad one gets its checksum byte flipped.
    task automatic send_frame(logic [15:0] frame_dist, logic [15:0] strength, bit bad);
        logic [7:0] fb [9];
        logic [7:0] s;
        int         k;
        fb[0] = HEADER_BYTE;
        fb[1] = HEADER_BYTE;
        fb[2] = frame_dist[7:0];
        fb[3] = frame_dist[15:8];
        fb[4] = strength[7:0];
        fb[5] = strength[15:8];
        fb[6] = 8'($urandom);
        fb[7] = 8'($urandom);
        s     = 8'd0;
        for (k = 0; k < 8; k++) begin
            s = s + fb[k];
        end
        fb[8] = bad ? (s ^ 8'($urandom_range(1, 255))) : s;
        for (k = 0; k < 9; k++) begin
            send_byte(fb[k]);
        end
        if (!bad) begin
            last_dist = frame_dist;
        end
    endtask

    // Wait out every expected reading, then the pipeline itself.
    task automatic wait_drained();
        @(posedge i_clk);
        while (readings_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup then access; leave the bus to the caller so back-to-back writes
    // never lower and raise a strobe in the same step.
    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // One random stretch: mostly clean frames, the rest corrupt frames,
    // line noise, broken headers and cut-off frames.
    task automatic send_random_chunk();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            send_frame(pick_dist(), pick_strength(), 1'b0);
        end else if (r < 85) begin
            send_frame(pick_dist(), pick_strength(), 1'b1);
        end else if (r < 93) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else if (r < 97) begin
            send_byte(HEADER_BYTE);
            send_byte(8'($urandom_range(0, int'(HEADER_BYTE) - 1)));
        end else begin
            send_byte(HEADER_BYTE);
            send_byte(HEADER_BYTE);
            k = $urandom_range(0, 6);
            repeat (k) send_byte(8'($urandom));
        end
    endtask

    initial begin
        logic [9:0]  rate;
        logic [15:0] min_str;
        logic [7:0]  deadband;
        int          phase_start;
        bit          paused;
        i_rst_n    <= 1'b0;
        i_push     <= 1'b0;
        i_rx_byte  <= 8'd0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        gaps_on     = 1'b1;
        bytes_sent  = 0;
        last_dist   = 16'd0;
        cur_min     = MIN_STR_RST;
        cur_db      = DEADBAND_RST;
        paused      = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: noise while hunting, a header broken at its second byte,
        // an all-ones frame past the distance limit, a bad checksum, and a
        // zero-distance frame just under the strength minimum.
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(HEADER_BYTE);
        send_byte(8'h00);
        send_frame(16'hFFFF, 16'hFFFF, 1'b0);
        send_frame(DISTANCE_LIMIT, MIN_STR_RST, 1'b1);
        send_frame(16'h0000, MIN_STR_RST - 16'd1, 1'b0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    rate = RATE_RST;  min_str = MIN_STR_RST; deadband = DEADBAND_RST;
                end
                1: begin
                    rate = 10'd0;     min_str = 16'd0;       deadband = 8'd0;
                end
                2: begin
                    rate = 10'd1023;  min_str = 16'hFFFF;    deadband = 8'd255;
                end
                3: begin
                    rate = 10'd1;     min_str = 16'd1;       deadband = 8'd1;
                end
                4: begin
                    rate     = 10'($urandom_range(1, 1000));
                    min_str  = 16'($urandom);
                    deadband = 8'($urandom);
                end
                default: begin
                    rate = 10'd1000;  min_str = 16'd500;     deadband = 8'd20;
                end
            endcase
            // Reconfigure only with the block fully drained.
            idle_input();
            wait_drained();
            write_reg(reg_addr(REG_RATE), {22'd0, rate});
            write_reg(reg_addr(REG_MIN_STR), {16'd0, min_str});
            write_reg(reg_addr(REG_DEADBAND), {24'd0, deadband});
            if (ph == 4) begin
                write_reg(SPARE_ADDR, $urandom);
            end
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            cur_min = min_str;
            cur_db  = deadband;
            // One phase runs without any idling on either side.
            gaps_on     = (ph != 1);
            pop_stalls <= (ph != 1);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                // Halfway through one phase, hold off until every reading is out.
                if (ph == 2 && !paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
                    idle_input();
                    wait_drained();
                    paused = 1'b1;
                end
                send_random_chunk();
            end
        end

        idle_input();
        wait_drained();
        if (fail_count == 0) begin
            $display("lidar_frame_parse_and_filter_core: match");
        end else begin
            $display("lidar_frame_parse_and_filter_core: mismatch");
        end
        $finish;
    end

endmodule
